[rtl/core/tracked_object_crop_limiter_defines.svh]
// Assertion macros for the crop limiter RTL.
// Uses clk and rst_n of the including module; ASSERT_OFF removes all checks.
`ifndef TRACKED_OBJECT_CROP_LIMITER_DEFINES_SVH
`define TRACKED_OBJECT_CROP_LIMITER_DEFINES_SVH

`ifndef ASSERT_OFF
`define TOCL_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`define TOCL_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define TOCL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define TOCL_ASSERT_ALWAYS(lbl, cond, msg)
`define TOCL_ASSERT_SAME(lbl, ante, cons, msg)
`define TOCL_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

[rtl/core/tocl_pkg.sv]
// Shared types and constants for the tracked object crop limiter.
// No dependencies.
`default_nettype none

package tocl_pkg;

  localparam int TRACK_ENTRIES_DEF = 64;

  localparam int ID_W    = 32;
  localparam int CLASS_W = 8;
  localparam int CNT_W   = 8;
  localparam int CAP_W   = 7;
  localparam int STAT_W  = 3;
  localparam int CIDX_W  = 2;
  localparam int CDATA_W = 8;

  localparam logic [STAT_W-1:0] ST_NEW      = 3'd0;
  localparam logic [STAT_W-1:0] ST_REACHED  = 3'd1;
  localparam logic [STAT_W-1:0] ST_COUNTING = 3'd2;
  localparam logic [STAT_W-1:0] ST_CLASS    = 3'd3;
  localparam logic [STAT_W-1:0] ST_UNTRACK  = 3'd4;
  localparam logic [STAT_W-1:0] ST_CAP      = 3'd5;
  localparam logic [STAT_W-1:0] ST_FRAME    = 3'd6;

  localparam logic [CIDX_W-1:0] CFG_TARGET_CLASS  = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_CROP_INTERVAL = 2'd1;
  localparam logic [CIDX_W-1:0] CFG_MAX_CROPS     = 2'd2;

  localparam logic [CLASS_W-1:0] TARGET_CLASS_RST  = 8'd0;
  localparam logic [CNT_W-1:0]   CROP_INTERVAL_RST = 8'd15;
  localparam logic [CAP_W-1:0]   MAX_CROPS_RST     = 7'd8;
  localparam logic [CAP_W-1:0]   GRANTS_SAT        = 7'd127;

  // lookup word travelling down the cell row
  typedef struct packed {
    logic              vld;
    logic              done;
    logic              crop;
    logic [STAT_W-1:0] status;
    logic [ID_W-1:0]   id;
  } tok_t;

endpackage

`default_nettype wire

[rtl/core/tracked_object_crop_limiter.sv]
// Tracked object crop limiter, top level: control, config registers, result buffer.
// Frame start and skipped words: result moves via the holding register to the output register.
// Table words: the token walks tok_r and the cell row, then the holding and output registers;
// one word in flight, next accepted once the result leaves the holding register, so
// out_tready low stalls the input.
// Reset (rst_n low, synchronous): table empty, frame counters and config to defaults.
`default_nettype none
`include "tracked_object_crop_limiter_defines.svh"

module tracked_object_crop_limiter #(
  parameter int TRACK_ENTRIES = tocl_pkg::TRACK_ENTRIES_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_tvalid,
  output logic                              in_tready,
  // [7:0] class_code, [8] is_tracked, [40:9] track_id, [47:41] zero
  input  wire logic [47:0]                  in_tdata,
  // [0] command
  input  wire logic                         in_tuser,
  output logic                              out_tvalid,
  input  wire logic                         out_tready,
  // [0] crop, [3:1] status, [4] table_full, [7:5] zero
  output logic [7:0]                        out_tdata,
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [tocl_pkg::CIDX_W-1:0]  cfg_index,
  input  wire logic [tocl_pkg::CDATA_W-1:0] cfg_data
);
  import tocl_pkg::*;

  logic [CLASS_W-1:0] target_class_r;
  logic [CNT_W-1:0]   crop_interval_r;
  logic [CAP_W-1:0]   max_crops_r;

  logic [CAP_W-1:0]   grants_r, grants_nxt, grants_inc;
  logic               closed_r, closed_nxt;
  logic               look_r, look_nxt;
  logic               pend_r, pend_nxt;
  logic               out_valid_r, out_valid_nxt;
  tok_t               tok_r, tok_nxt, chain_out;

  logic               res_crop_r, res_crop_nxt;
  logic [STAT_W-1:0]  res_stat_r, res_stat_nxt;
  logic               res_full_r, res_full_nxt;
  logic               o_crop_r, o_crop_nxt;
  logic [STAT_W-1:0]  o_stat_r, o_stat_nxt;
  logic               o_full_r, o_full_nxt;

  logic               in_acc, cmd, tracked, lookup, load_out, grant;
  logic [CLASS_W-1:0] cls;
  logic [ID_W-1:0]    tid;

  assign cmd     = in_tuser;
  assign cls     = in_tdata[7:0];
  assign tracked = in_tdata[8];
  assign tid     = in_tdata[40:9];

  assign in_tready = !look_r && !pend_r;
  assign in_acc    = in_tvalid && in_tready;
  assign lookup    = !cmd && !closed_r && (cls == target_class_r) && tracked;
  assign load_out  = pend_r && (!out_valid_r || out_tready);
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_class_r  <= TARGET_CLASS_RST;
      crop_interval_r <= CROP_INTERVAL_RST;
      max_crops_r     <= MAX_CROPS_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_TARGET_CLASS:  target_class_r  <= cfg_data;
        CFG_CROP_INTERVAL: crop_interval_r <= cfg_data;
        CFG_MAX_CROPS:     max_crops_r     <= cfg_data[CAP_W-1:0];
        default: ;
      endcase
    end
  end

  tocl_chain #(
    .TRACK_ENTRIES (TRACK_ENTRIES)
  ) u_chain (
    .clk           (clk),
    .rst_n         (rst_n),
    .crop_interval (crop_interval_r),
    .tok_in        (tok_r),
    .tok_out       (chain_out)
  );

  // missing from the table counts as a grant (new track, maybe table full)
  assign grant      = chain_out.vld && (chain_out.crop || !chain_out.done);
  assign grants_inc = (grants_r < GRANTS_SAT) ? grants_r + 1'b1 : grants_r;

  always_comb begin
    look_nxt     = look_r;
    pend_nxt     = pend_r;
    grants_nxt   = grants_r;
    closed_nxt   = closed_r;
    tok_nxt      = '0;
    tok_nxt.id   = tid;
    res_crop_nxt = res_crop_r;
    res_stat_nxt = res_stat_r;
    res_full_nxt = res_full_r;

    if (load_out) pend_nxt = 1'b0;

    if (in_acc) begin
      if (lookup) begin
        look_nxt    = 1'b1;
        tok_nxt.vld = 1'b1;
      end else begin
        pend_nxt     = 1'b1;
        res_crop_nxt = 1'b0;
        res_full_nxt = 1'b0;
        if (cmd) begin
          res_stat_nxt = ST_FRAME;
          grants_nxt   = '0;
          closed_nxt   = 1'b0;
        end else if (closed_r) begin
          res_stat_nxt = ST_CAP;
        end else if (cls != target_class_r) begin
          res_stat_nxt = ST_CLASS;
        end else begin
          res_stat_nxt = ST_UNTRACK;
        end
      end
    end

    if (chain_out.vld) begin
      look_nxt     = 1'b0;
      pend_nxt     = 1'b1;
      res_crop_nxt = grant;
      res_stat_nxt = chain_out.done ? chain_out.status : ST_NEW;
      res_full_nxt = !chain_out.done;
      if (grant) begin
        grants_nxt = grants_inc;
        if (grants_inc >= max_crops_r) closed_nxt = 1'b1;
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    o_crop_nxt    = o_crop_r;
    o_stat_nxt    = o_stat_r;
    o_full_nxt    = o_full_r;
    if (out_tready) out_valid_nxt = 1'b0;
    if (load_out) begin
      out_valid_nxt = 1'b1;
      o_crop_nxt    = res_crop_r;
      o_stat_nxt    = res_stat_r;
      o_full_nxt    = res_full_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      look_r      <= 1'b0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
      grants_r    <= '0;
      closed_r    <= 1'b0;
      tok_r       <= '0;
    end else begin
      look_r      <= look_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
      grants_r    <= grants_nxt;
      closed_r    <= closed_nxt;
      tok_r       <= tok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_crop_r <= res_crop_nxt;
    res_stat_r <= res_stat_nxt;
    res_full_r <= res_full_nxt;
    o_crop_r   <= o_crop_nxt;
    o_stat_r   <= o_stat_nxt;
    o_full_r   <= o_full_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, o_full_r, o_stat_r, o_crop_r};

  `TOCL_ASSERT_SAME(a_tok_only_in_lookup, chain_out.vld, look_r, "token out of chain with no lookup")
  `TOCL_ASSERT_ALWAYS(a_one_item, !(look_r && pend_r), "lookup and held result at once")
  `TOCL_ASSERT_NEXT(a_busy_after_accept, in_acc, !in_tready, "accepted a word while busy")
  `TOCL_ASSERT_SAME(a_full_is_new_grant, out_tvalid && o_full_r,
                    o_crop_r && (o_stat_r == ST_NEW), "table_full without new-track grant")

endmodule

`default_nettype wire

[rtl/core/tocl_cell.sv]
// One table entry: track id, counter and valid bit, plus one token stage.
// Depends on tocl_pkg.
`default_nettype none

module tocl_cell (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic [tocl_pkg::CNT_W-1:0] crop_interval,
  input  wire tocl_pkg::tok_t            tok_in,
  output tocl_pkg::tok_t                 tok_out
);
  import tocl_pkg::*;

  logic             valid_r, valid_nxt;
  logic [ID_W-1:0]  id_r, id_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  tok_t             tok_r, tok_nxt;

  always_comb begin
    valid_nxt = valid_r;
    id_nxt    = id_r;
    cnt_nxt   = cnt_r;
    tok_nxt   = tok_in;
    if (tok_in.vld && !tok_in.done) begin
      if (valid_r && (id_r == tok_in.id)) begin
        tok_nxt.done = 1'b1;
        if (cnt_r >= crop_interval) begin
          cnt_nxt        = '0;
          tok_nxt.crop   = 1'b1;
          tok_nxt.status = ST_REACHED;
        end else begin
          cnt_nxt        = cnt_r + 1'b1;
          tok_nxt.crop   = 1'b0;
          tok_nxt.status = ST_COUNTING;
        end
      end else if (!valid_r) begin
        // entries fill from the low end, so no hit can lie past a free one
        valid_nxt      = 1'b1;
        id_nxt         = tok_in.id;
        cnt_nxt        = '0;
        tok_nxt.done   = 1'b1;
        tok_nxt.crop   = 1'b1;
        tok_nxt.status = ST_NEW;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      tok_r   <= '0;
    end else begin
      valid_r <= valid_nxt;
      tok_r   <= tok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    id_r  <= id_nxt;
    cnt_r <= cnt_nxt;
  end

  assign tok_out = tok_r;

endmodule

`default_nettype wire

[rtl/core/tocl_chain.sv]
// Row of TRACK_ENTRIES table cells; a lookup token moves one cell per cycle.
// Depends on tocl_pkg and tocl_cell.
`default_nettype none

module tocl_chain #(
  parameter int TRACK_ENTRIES = tocl_pkg::TRACK_ENTRIES_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic [tocl_pkg::CNT_W-1:0] crop_interval,
  input  wire tocl_pkg::tok_t            tok_in,
  output tocl_pkg::tok_t                 tok_out
);
  import tocl_pkg::*;

  tok_t link [TRACK_ENTRIES+1];

  assign link[0] = tok_in;

  for (genvar g = 0; g < TRACK_ENTRIES; g++) begin : g_cell
    tocl_cell u_cell (
      .clk           (clk),
      .rst_n         (rst_n),
      .crop_interval (crop_interval),
      .tok_in        (link[g]),
      .tok_out       (link[g+1])
    );
  end

  assign tok_out = link[TRACK_ENTRIES];

endmodule

`default_nettype wire

[dv/tracked_object_crop_limiter_tb.sv]
// Testbench for tracked_object_crop_limiter: directed and random words, checked against
// an in-bench predictor of the track table and per-frame crop budget.
// Depends on tocl_pkg and the crop limiter RTL.
`default_nettype none

module tracked_object_crop_limiter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tocl_pkg::*;

  localparam int N_TRACKS      = TRACK_ENTRIES_DEF;
  localparam int TRK_IDX_W     = $clog2(N_TRACKS);
  localparam int WATCHDOG_MAX  = 3000;
  localparam int PHASE_WORDS   = 600;

  typedef struct packed {
    logic              crop;
    logic [STAT_W-1:0] status;
    logic              full;
  } verdict_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_tvalid = 1'b0;
  logic                in_tready;
  logic [47:0]         in_tdata = '0;
  logic                in_tuser = 1'b0;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [7:0]          out_tdata;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CIDX_W-1:0]   cfg_index = '0;
  logic [CDATA_W-1:0]  cfg_data = '0;

  // predictor state
  bit [ID_W-1:0]    tbl_id [N_TRACKS];
  bit               tbl_live [N_TRACKS];
  bit [CNT_W-1:0]   tbl_count [N_TRACKS];
  int               entries_used = 0;
  bit [CAP_W-1:0]   grants_this_frame = '0;
  bit               frame_capped = 1'b0;
  bit [CLASS_W-1:0] cur_target = TARGET_CLASS_RST;
  bit [CNT_W-1:0]   cur_interval = CROP_INTERVAL_RST;
  bit [CAP_W-1:0]   cur_max_crops = MAX_CROPS_RST;

  verdict_t pending_verdicts[$];
  verdict_t want;
  int       mismatches = 0;
  int       idle_cycles = 0;
  int       in_idle_pct = 0;
  int       out_idle_pct = 0;
  bit [ID_W-1:0] track_pool [8];

  tracked_object_crop_limiter dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic verdict_t decide_crop(bit cmd, bit [CLASS_W-1:0] cls, bit trk,
                                           bit [ID_W-1:0] id);
    verdict_t v;
    int hit;
    int free_slot;
    int i;
    v = '{crop: 1'b0, status: ST_FRAME, full: 1'b0};
    hit = -1;
    free_slot = -1;
    if (cmd) begin
      grants_this_frame = '0;
      frame_capped = 1'b0;
      v.status = ST_FRAME;
    end else if (frame_capped) begin
      v.status = ST_CAP;
    end else if (cls != cur_target) begin
      v.status = ST_CLASS;
    end else if (!trk) begin
      v.status = ST_UNTRACK;
    end else begin
      for (i = 0; i < N_TRACKS; i++) begin
        if (tbl_live[i]) begin
          if (hit < 0 && tbl_id[i] == id) hit = i;
        end else if (free_slot < 0) begin
          free_slot = i;
        end
      end
      if (hit >= 0) begin
        if (tbl_count[hit] >= cur_interval) begin
          tbl_count[hit] = '0;
          v.crop = 1'b1;
          v.status = ST_REACHED;
        end else begin
          tbl_count[hit] = tbl_count[hit] + 1'b1;
          v.status = ST_COUNTING;
        end
      end else begin
        if (free_slot >= 0) begin
          tbl_id[free_slot] = id;
          tbl_count[free_slot] = '0;
          tbl_live[free_slot] = 1'b1;
          entries_used++;
        end else begin
          v.full = 1'b1;
        end
        v.crop = 1'b1;
        v.status = ST_NEW;
      end
      if (v.crop) begin
        if (grants_this_frame < GRANTS_SAT) grants_this_frame = grants_this_frame + 1'b1;
        if (grants_this_frame >= cur_max_crops) frame_capped = 1'b1;
      end
    end
    return v;
  endfunction

  task automatic push_word(input bit cmd, input bit [CLASS_W-1:0] cls, input bit trk,
                           input bit [ID_W-1:0] id);
    while ($urandom_range(99) < in_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {7'd0, id, trk, cls};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_verdicts.push_back(decide_crop(cmd, cls, trk, id));
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CIDX_W-1:0] idx, input bit [7:0] val);
    wait_drained();
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_TARGET_CLASS:  cur_target = val;
      CFG_CROP_INTERVAL: cur_interval = val;
      CFG_MAX_CROPS:     cur_max_crops = val[CAP_W-1:0];
      default: ;
    endcase
  endtask

  // skip reasons, frame cap, interval zero and a zero crop budget
  task automatic test_directed();
    push_word(1'b1, 8'hFF, 1'b1, 32'hFFFF_FFFF);
    push_word(1'b0, 8'hFF, 1'b1, 32'h0000_0000);
    push_word(1'b0, 8'h00, 1'b0, 32'hFFFF_FFFF);
    push_word(1'b0, 8'h00, 1'b1, 32'h0000_0000);
    push_word(1'b0, 8'h00, 1'b1, 32'h0000_0000);
    push_word(1'b0, 8'h00, 1'b1, 32'hFFFF_FFFF);
    push_word(1'b0, 8'h00, 1'b1, 32'hAAAA_AAAA);
    push_word(1'b0, 8'h00, 1'b1, 32'h5555_5555);
    push_word(1'b0, 8'h00, 1'b1, 32'h0000_0001);
    push_word(1'b0, 8'h00, 1'b1, 32'h0000_0002);
    push_word(1'b0, 8'h00, 1'b1, 32'h0000_0003);
    push_word(1'b0, 8'h00, 1'b1, 32'h0000_0004);
    push_word(1'b0, 8'hFF, 1'b0, 32'h0000_0005);
    push_word(1'b1, 8'h00, 1'b0, 32'h0000_0000);
    write_reg(CFG_TARGET_CLASS, 8'hFF);
    write_reg(CFG_CROP_INTERVAL, 8'd0);
    push_word(1'b0, 8'hFF, 1'b1, 32'h0000_0000);
    push_word(1'b0, 8'hFF, 1'b1, 32'h0000_0000);
    push_word(1'b0, 8'h00, 1'b1, 32'h0000_0000);
    write_reg(CFG_MAX_CROPS, 8'd0);
    push_word(1'b1, 8'h5A, 1'b1, 32'h1234_5678);
    push_word(1'b0, 8'hFF, 1'b1, 32'hAAAA_AAAA);
    push_word(1'b0, 8'hFF, 1'b1, 32'h0000_0001);
    push_word(1'b1, 8'hA5, 1'b0, 32'h8765_4321);
  endtask

  task automatic test_random_phase(input int words);
    int s;
    int n;
    int r;
    bit [7:0] val;
    for (n = 0; n < 8; n++) track_pool[n] = $urandom;
    for (s = 0; s < 4; s++) begin
      val = (s == 0) ? 8'h00 : (s == 1) ? 8'hFF : 8'($urandom_range(255));
      write_reg(CFG_TARGET_CLASS, val);
      val = (s == 0) ? 8'd255 : (s == 1) ? 8'd0 : 8'($urandom_range(5));
      write_reg(CFG_CROP_INTERVAL, val);
      val = (s == 2) ? 8'd1 : (s == 3) ? 8'd64 : 8'($urandom_range(1, 64));
      write_reg(CFG_MAX_CROPS, val);
      for (n = 0; n < words / 4; n++) begin
        r = $urandom_range(99);
        if (r < 8)
          push_word(1'b1, CLASS_W'($urandom), 1'($urandom), $urandom);
        else if (r < 78)
          push_word(1'b0, cur_target, 1'b1, track_pool[3'($urandom_range(7))]);
        else if (r < 86)
          push_word(1'b0, cur_target, 1'b0, $urandom);
        else
          push_word(1'b0, CLASS_W'($urandom), 1'($urandom), $urandom);
        if ($urandom_range(49) == 0) wait_drained();
      end
    end
  endtask

  // fill every entry, then unknown ids are granted but flagged
  task automatic test_table_full();
    int k;
    int r;
    write_reg(CFG_MAX_CROPS, 8'd64);
    write_reg(CFG_CROP_INTERVAL, 8'd2);
    k = 0;
    while (entries_used < N_TRACKS) begin
      if (k % 32 == 0) push_word(1'b1, CLASS_W'($urandom), 1'($urandom), $urandom);
      push_word(1'b0, cur_target, 1'b1, $urandom);
      k++;
    end
    for (k = 0; k < 90; k++) begin
      r = $urandom_range(99);
      if (r < 10)
        push_word(1'b1, CLASS_W'($urandom), 1'($urandom), $urandom);
      else if (r < 50)
        push_word(1'b0, cur_target, 1'b1, $urandom);
      else
        push_word(1'b0, cur_target, 1'b1,
                  tbl_id[TRK_IDX_W'($urandom_range(N_TRACKS - 1))]);
    end
  endtask

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= out_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_verdicts.size() == 0) begin
        $error("unexpected result word %h", out_tdata);
        mismatches++;
      end else begin
        want = pending_verdicts.pop_front();
        if (out_tdata[0] !== want.crop) begin
          $error("crop: expected %0d, got %0d", want.crop, out_tdata[0]);
          mismatches++;
        end
        if (out_tdata[3:1] !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_tdata[3:1]);
          mismatches++;
        end
        if (out_tdata[4] !== want.full) begin
          $error("table_full: expected %0d, got %0d", want.full, out_tdata[4]);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_MAX) begin
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    in_idle_pct  = 37;
    out_idle_pct = 65;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random_phase(PHASE_WORDS);
    in_idle_pct  = 65;
    out_idle_pct = 37;
    test_random_phase(PHASE_WORDS);
    in_idle_pct  = 0;
    out_idle_pct = 0;
    test_random_phase(PHASE_WORDS);
    test_table_full();
    wait_drained();
    repeat (N_TRACKS + 8) @(posedge clk);
    if (mismatches == 0 && pending_verdicts.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
